@@ src/rsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-slice line rasterizer package
// Shared constants, request types and state encodings for the line engine.
// ----------------------------------------------------------------------------
package rsl_pkg;

    // Fraction bits of the step ratio and the overstep accumulator.
    localparam int FRAC_BITS = 16;

    // Field widths.
    localparam int COORD_IN_W = 16;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 13;
    localparam int SPAN_W     = 15;
    localparam int ADDR_W     = 22;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Frame size limits; larger register values saturate to these.
    localparam logic [DIM_W:0] MAX_WIDTH  = 13'd2048;
    localparam logic [DIM_W:0] MAX_HEIGHT = 13'd2048;

    // Register reset values.
    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST   = 32'h00FF_FFFF;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = 2'd2;

    // Command actions.
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // Command request: one load or one drawing tick.
    typedef struct packed {
        logic                         action;
        logic signed [COORD_IN_W-1:0] start_x;
        logic signed [COORD_IN_W-1:0] start_y;
        logic signed [COORD_IN_W-1:0] end_x;
        logic signed [COORD_IN_W-1:0] end_y;
    } cmd_req_t;

    // Pixel request: one framebuffer write.
    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_value;
        logic               last_pixel;
    } pix_req_t;

    // Main sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_AXIS,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROUND,
        ST_ADDR,
        ST_ACC,
        ST_LEN,
        ST_CHECK,
        ST_EMIT
    } ctrl_state_t;

    // Divider states.
    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

endpackage

@@ src/rsl_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle with a single shared subtractor.
// ----------------------------------------------------------------------------
module rsl_divider #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    rsl_pkg::div_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W:0]      trial;

    // Shift in the next numerator bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_reg};

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        unique case (state_reg)
            rsl_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    quo_next   = numerator;
                    den_next   = denominator;
                    count_next = CNT_W'(NUM_W);
                    state_next = rsl_pkg::DIV_RUN;
                end
            end
            rsl_pkg::DIV_RUN:
            begin
                if (!trial[DEN_W])
                begin
                    rem_next = trial[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = rsl_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = rsl_pkg::DIV_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsl_pkg::DIV_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/run_slice_line_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-slice line rasterizer
// Clamps a line to the frame and walks it run by run, one pixel per tick.
// ----------------------------------------------------------------------------
// Usage:
// Register writes (cfg_write, cfg_index, cfg_data) set frame width, frame
// height and draw color; write them only while the engine is idle; the
// block itself does not enforce this. The command channel (cmd_valid,
// cmd_stall, cmd_req) carries either a load request with two endpoints or a
// tick request. A load runs the step ratio through an iterative divider that
// retires one quotient bit per cycle; cmd_stall stays high until the load ends.
// A tick while a line is active yields one pixel request on the pixel
// channel (pix_valid, pix_stall, pix_req): the address is registered, and
// when a run ends the overstep, next run length and early stop are worked
// out before the request is written. A tick while idle yields nothing.
// The pixel request sits in an output register. A new command is taken while
// it waits; a stalled receiver only holds the engine once the next pixel is
// ready and the register is still full.
// Reset ends any active line, empties the output register and restores the
// register defaults (640 x 480, white).
// ----------------------------------------------------------------------------
module run_slice_line_rasterizer #(
    parameter int FRAC_BITS = rsl_pkg::FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  rsl_pkg::cmd_req_t                cmd_req,
    output logic                             pix_valid,
    input  logic                             pix_stall,
    output rsl_pkg::pix_req_t                pix_req
);

    localparam int DIM_W   = rsl_pkg::DIM_W;
    localparam int POS_W   = rsl_pkg::POS_W;
    localparam int SPAN_W  = rsl_pkg::SPAN_W;
    localparam int ADDR_W  = rsl_pkg::ADDR_W;
    localparam int COLOR_W = rsl_pkg::COLOR_W;
    localparam int IN_W    = rsl_pkg::COORD_IN_W;
    localparam int EXT_W   = IN_W + 1;
    localparam int SR_W    = DIM_W + FRAC_BITS;
    localparam int ACC_W   = FRAC_BITS + 2;
    localparam int NUM_W   = SR_W + 1;
    localparam int DEN_W   = DIM_W + 1;
    localparam int V_W     = SR_W + 1;
    localparam logic [SR_W-1:0] HALF = {{(SR_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    // Clamp one coordinate to [0, size-1], upper edge first.
    function automatic logic [DIM_W-1:0] clamp_axis(
        input logic signed [IN_W-1:0] v,
        input logic [DIM_W-1:0]       size
    );
        logic signed [EXT_W-1:0] v_ext;
        logic signed [EXT_W-1:0] sz;
        logic signed [EXT_W-1:0] t;
        v_ext = {v[IN_W-1], v};
        sz    = $signed({{(EXT_W-DIM_W){1'b0}}, size});
        t     = (v_ext >= sz) ? sz - EXT_W'(1) : v_ext;
        return (t < 0) ? '0 : t[DIM_W-1:0];
    endfunction

    // True when a coordinate is at or past the upper frame edge.
    function automatic logic at_or_past(
        input logic signed [IN_W-1:0] v,
        input logic [DIM_W-1:0]       size
    );
        return $signed({v[IN_W-1], v}) >= $signed({{(EXT_W-DIM_W){1'b0}}, size});
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [COLOR_W-1:0] draw_color_reg;
    logic [DIM_W-1:0]   eff_width;
    logic [DIM_W-1:0]   eff_height;

    // Control state.
    rsl_pkg::ctrl_state_t state_reg, state_next;
    logic                 busy_reg, busy_next;
    logic                 pix_valid_reg, pix_valid_next;

    // Endpoint capture and clamped coordinates.
    logic signed [IN_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic signed [IN_W-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic [DIM_W-1:0]       cx1_reg, cx1_next, cy1_reg, cy1_next;
    logic [DIM_W-1:0]       cx2_reg, cx2_next, cy2_reg, cy2_next;

    // Line state.
    logic                    axes_swapped_reg, axes_swapped_next;
    logic signed [POS_W-1:0] major_pos_reg, major_pos_next;
    logic [DIM_W-1:0]        major_end_reg, major_end_next;
    logic                    major_dir_neg_reg, major_dir_neg_next;
    logic                    minor_dir_neg_reg, minor_dir_neg_next;
    logic signed [POS_W-1:0] run_start_reg, run_start_next;
    logic signed [POS_W-1:0] run_pos_reg, run_pos_next;
    logic [DIM_W-1:0]        run_length_reg, run_length_next;
    logic [SR_W-1:0]         step_ratio_reg, step_ratio_next;
    logic signed [ACC_W-1:0] overstep_acc_reg, overstep_acc_next;

    // Working registers for the load and the tick.
    logic [DIM_W-1:0]         major_len_reg, major_len_next;
    logic [DIM_W-1:0]         minor_len_reg, minor_len_next;
    logic [ADDR_W-1:0]        addr_reg, addr_next;
    logic                     last_reg, last_next;
    logic signed [SPAN_W-1:0] next_start_reg, next_start_next;
    logic [DIM_W-1:0]         next_len_reg, next_len_next;
    rsl_pkg::pix_req_t        pix_req_reg, pix_req_next;

    // Combinational intermediates.
    logic                     cmd_accept;
    logic                     drop_line;
    logic                     xneg, yneg;
    logic [DIM_W-1:0]         wdt, hgt;
    logic [SR_W:0]            round_sum;
    logic signed [POS_W-1:0]  row, col;
    logic [ADDR_W-1:0]        row_ext, col_ext, width_ext, addr_prod;
    logic                     at_end;
    logic signed [POS_W-1:0]  major_step;
    logic signed [SPAN_W-1:0] run_start_ext, run_length_ext, next_start;
    logic                     run_done;
    logic [SR_W-1:0]          acc_delta;
    logic signed [V_W-1:0]    len_value;
    logic signed [SPAN_W-1:0] run_end;
    logic [DIM_W-1:0]         screen;

    // Divider interface.
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    rsl_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_rsl_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (div_num),
        .denominator (div_den),
        .done        (div_done),
        .quotient    (div_quo)
    );

    // Frame sizes saturate to the supported maximum.
    assign eff_width  = ({1'b0, frame_width_reg} > rsl_pkg::MAX_WIDTH) ?
                        rsl_pkg::MAX_WIDTH[DIM_W-1:0] : frame_width_reg;
    assign eff_height = ({1'b0, frame_height_reg} > rsl_pkg::MAX_HEIGHT) ?
                        rsl_pkg::MAX_HEIGHT[DIM_W-1:0] : frame_height_reg;

    assign cmd_stall  = (state_reg != rsl_pkg::ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // Drop tests on the raw endpoints.
    assign drop_line = (at_or_past(x1_reg, eff_width) && at_or_past(x2_reg, eff_width)) ||
                       (at_or_past(y1_reg, eff_height) && at_or_past(y2_reg, eff_height)) ||
                       (y1_reg < 0 && y2_reg < 0);

    // Extents of the clamped line.
    assign xneg = cx1_reg > cx2_reg;
    assign yneg = cy1_reg > cy2_reg;
    assign wdt  = (xneg ? cx1_reg - cx2_reg : cx2_reg - cx1_reg) + DIM_W'(1);
    assign hgt  = (yneg ? cy1_reg - cy2_reg : cy2_reg - cy1_reg) + DIM_W'(1);

    // Divider operands: (major << (FRAC_BITS+1) + minor) / (2 * minor).
    assign div_num = {major_len_reg, {(FRAC_BITS+1){1'b0}}} + NUM_W'(minor_len_reg);
    assign div_den = {minor_len_reg, 1'b0};

    // First run length rounds the step ratio half up.
    assign round_sum = {1'b0, step_ratio_reg} + {1'b0, HALF};

    // Pixel address from the current position.
    assign row       = axes_swapped_reg ? major_pos_reg : run_pos_reg;
    assign col       = axes_swapped_reg ? run_pos_reg : major_pos_reg;
    assign row_ext   = {{(ADDR_W-POS_W){row[POS_W-1]}}, row};
    assign col_ext   = {{(ADDR_W-POS_W){col[POS_W-1]}}, col};
    assign width_ext = {{(ADDR_W-DIM_W){1'b0}}, eff_width};
    assign addr_prod = row_ext * width_ext;

    // Major step and run boundary test.
    assign at_end         = (major_pos_reg == $signed({1'b0, major_end_reg}));
    assign major_step     = major_dir_neg_reg ? major_pos_reg - POS_W'(1) :
                                                major_pos_reg + POS_W'(1);
    assign run_start_ext  = {{(SPAN_W-POS_W){run_start_reg[POS_W-1]}}, run_start_reg};
    assign run_length_ext = $signed({{(SPAN_W-DIM_W){1'b0}}, run_length_reg});
    assign next_start     = major_dir_neg_reg ? run_start_ext - run_length_ext :
                                                run_start_ext + run_length_ext;
    assign run_done       = ({{(SPAN_W-POS_W){major_step[POS_W-1]}}, major_step} == next_start);

    // Overstep update: only the low bits matter, the result stays within half a pixel.
    assign acc_delta = {run_length_reg, {FRAC_BITS{1'b0}}} - step_ratio_reg;

    // Next run length rounds (step_ratio - overstep) half up.
    assign len_value = $signed({1'b0, step_ratio_reg})
                     - {{(V_W-ACC_W){overstep_acc_reg[ACC_W-1]}}, overstep_acc_reg}
                     + $signed({1'b0, HALF});

    // Early stop compares the next run end with the major frame size.
    assign screen  = axes_swapped_reg ? eff_height : eff_width;
    assign run_end = next_start_reg + $signed({{(SPAN_W-DIM_W){1'b0}}, next_len_reg});

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next         = state_reg;
        busy_next          = busy_reg;
        pix_valid_next     = pix_valid_reg;
        x1_next            = x1_reg;
        y1_next            = y1_reg;
        x2_next            = x2_reg;
        y2_next            = y2_reg;
        cx1_next           = cx1_reg;
        cy1_next           = cy1_reg;
        cx2_next           = cx2_reg;
        cy2_next           = cy2_reg;
        axes_swapped_next  = axes_swapped_reg;
        major_pos_next     = major_pos_reg;
        major_end_next     = major_end_reg;
        major_dir_neg_next = major_dir_neg_reg;
        minor_dir_neg_next = minor_dir_neg_reg;
        run_start_next     = run_start_reg;
        run_pos_next       = run_pos_reg;
        run_length_next    = run_length_reg;
        step_ratio_next    = step_ratio_reg;
        overstep_acc_next  = overstep_acc_reg;
        major_len_next     = major_len_reg;
        minor_len_next     = minor_len_reg;
        addr_next          = addr_reg;
        last_next          = last_reg;
        next_start_next    = next_start_reg;
        next_len_next      = next_len_reg;
        pix_req_next       = pix_req_reg;
        div_start          = 1'b0;

        // The receiver takes the waiting pixel request.
        if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end

        unique case (state_reg)
            rsl_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd_req.action == rsl_pkg::ACTION_LOAD)
                    begin
                        x1_next    = cmd_req.start_x;
                        y1_next    = cmd_req.start_y;
                        x2_next    = cmd_req.end_x;
                        y2_next    = cmd_req.end_y;
                        busy_next  = 1'b0;
                        state_next = rsl_pkg::ST_CLAMP;
                    end
                    else if (busy_reg)
                    begin
                        state_next = rsl_pkg::ST_ADDR;
                    end
                end
            end
            rsl_pkg::ST_CLAMP:
            begin
                cx1_next = clamp_axis(x1_reg, eff_width);
                cx2_next = clamp_axis(x2_reg, eff_width);
                cy1_next = clamp_axis(y1_reg, eff_height);
                cy2_next = clamp_axis(y2_reg, eff_height);
                state_next = drop_line ? rsl_pkg::ST_IDLE : rsl_pkg::ST_AXIS;
            end
            rsl_pkg::ST_AXIS:
            begin
                axes_swapped_next = (wdt < hgt);
                if (wdt < hgt)
                begin
                    major_len_next     = hgt;
                    minor_len_next     = wdt;
                    major_pos_next     = $signed({1'b0, cy1_reg});
                    major_end_next     = cy2_reg;
                    run_pos_next       = $signed({1'b0, cx1_reg});
                    major_dir_neg_next = yneg;
                    minor_dir_neg_next = xneg;
                end
                else
                begin
                    major_len_next     = wdt;
                    minor_len_next     = hgt;
                    major_pos_next     = $signed({1'b0, cx1_reg});
                    major_end_next     = cx2_reg;
                    run_pos_next       = $signed({1'b0, cy1_reg});
                    major_dir_neg_next = xneg;
                    minor_dir_neg_next = yneg;
                end
                state_next = rsl_pkg::ST_DIV_START;
            end
            rsl_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = rsl_pkg::ST_DIV_WAIT;
            end
            rsl_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    step_ratio_next = div_quo[SR_W-1:0];
                    state_next      = rsl_pkg::ST_ROUND;
                end
            end
            rsl_pkg::ST_ROUND:
            begin
                run_length_next   = round_sum[SR_W-1:FRAC_BITS];
                overstep_acc_next = '0;
                run_start_next    = major_pos_reg;
                busy_next         = 1'b1;
                state_next        = rsl_pkg::ST_IDLE;
            end
            rsl_pkg::ST_ADDR:
            begin
                addr_next = addr_prod + col_ext;
                last_next = at_end;
                if (at_end)
                begin
                    state_next = rsl_pkg::ST_EMIT;
                end
                else
                begin
                    major_pos_next  = major_step;
                    next_start_next = next_start;
                    state_next      = run_done ? rsl_pkg::ST_ACC : rsl_pkg::ST_EMIT;
                end
            end
            rsl_pkg::ST_ACC:
            begin
                overstep_acc_next = overstep_acc_reg + $signed(acc_delta[ACC_W-1:0]);
                state_next        = rsl_pkg::ST_LEN;
            end
            rsl_pkg::ST_LEN:
            begin
                next_len_next = (len_value < 0) ? '0 : len_value[SR_W-1:FRAC_BITS];
                state_next    = rsl_pkg::ST_CHECK;
            end
            rsl_pkg::ST_CHECK:
            begin
                if (run_end > $signed({{(SPAN_W-DIM_W){1'b0}}, screen}))
                begin
                    last_next = 1'b1;
                end
                else
                begin
                    run_start_next  = next_start_reg[POS_W-1:0];
                    run_length_next = next_len_reg;
                    run_pos_next    = minor_dir_neg_reg ? run_pos_reg - POS_W'(1) :
                                                          run_pos_reg + POS_W'(1);
                end
                state_next = rsl_pkg::ST_EMIT;
            end
            rsl_pkg::ST_EMIT:
            begin
                // Wait for room in the output register.
                if (!pix_valid_reg || !pix_stall)
                begin
                    pix_req_next.pixel_address = addr_reg;
                    pix_req_next.pixel_value   = draw_color_reg;
                    pix_req_next.last_pixel    = last_reg;
                    pix_valid_next             = 1'b1;
                    if (last_reg)
                    begin
                        busy_next = 1'b0;
                    end
                    state_next = rsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rsl_pkg::ST_IDLE;
            busy_reg         <= 1'b0;
            pix_valid_reg    <= 1'b0;
            frame_width_reg  <= rsl_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rsl_pkg::FRAME_HEIGHT_RST;
            draw_color_reg   <= rsl_pkg::DRAW_COLOR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            pix_valid_reg <= pix_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    rsl_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                    rsl_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                    rsl_pkg::CFG_DRAW_COLOR:   draw_color_reg   <= cfg_data[COLOR_W-1:0];
                    default:
                    begin
                        // Unused index: write ignored.
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x1_reg            <= x1_next;
        y1_reg            <= y1_next;
        x2_reg            <= x2_next;
        y2_reg            <= y2_next;
        cx1_reg           <= cx1_next;
        cy1_reg           <= cy1_next;
        cx2_reg           <= cx2_next;
        cy2_reg           <= cy2_next;
        axes_swapped_reg  <= axes_swapped_next;
        major_pos_reg     <= major_pos_next;
        major_end_reg     <= major_end_next;
        major_dir_neg_reg <= major_dir_neg_next;
        minor_dir_neg_reg <= minor_dir_neg_next;
        run_start_reg     <= run_start_next;
        run_pos_reg       <= run_pos_next;
        run_length_reg    <= run_length_next;
        step_ratio_reg    <= step_ratio_next;
        overstep_acc_reg  <= overstep_acc_next;
        major_len_reg     <= major_len_next;
        minor_len_reg     <= minor_len_next;
        addr_reg          <= addr_next;
        last_reg          <= last_next;
        next_start_reg    <= next_start_next;
        next_len_reg      <= next_len_next;
        pix_req_reg       <= pix_req_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix_req   = pix_req_reg;

endmodule

@@ src/rsl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-slice line rasterizer checker
// Port-level assertions on the command and pixel channels, bound to the top.
// ----------------------------------------------------------------------------
module rsl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input rsl_pkg::cmd_req_t cmd_req,
    input logic              pix_valid,
    input logic              pix_stall,
    input rsl_pkg::pix_req_t pix_req
);

    // A stalled pixel request stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(pix_req))
        else $error("pixel request changed while stalled");

    // A load keeps the engine busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd_req.action == rsl_pkg::ACTION_LOAD |=> cmd_stall)
        else $error("engine ready right after a load request");

    // A load never produces a pixel request.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd_req.action == rsl_pkg::ACTION_LOAD
        |=> !$rose(pix_valid))
        else $error("pixel request right after a load request");

    // A new pixel request comes only from a tick in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(cmd_stall))
        else $error("pixel request appeared while the engine was idle");

endmodule

bind run_slice_line_rasterizer rsl_checker u_rsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_req   (cmd_req),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_req   (pix_req)
);

@@ sim/tb_run_slice_line_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-slice line rasterizer testbench
// Sends load and tick requests with random idling on both channels, walks
// each line in a behavioral model of the engine and checks every pixel
// request against the oldest predicted one. A directed table comes first,
// then random phases that each program the frame registers.
// ----------------------------------------------------------------------------
module tb_run_slice_line_rasterizer;

    localparam int FRAC_BITS  = rsl_pkg::FRAC_BITS;
    localparam int DIM_W      = rsl_pkg::DIM_W;
    localparam int COLOR_W    = rsl_pkg::COLOR_W;
    localparam int ADDR_W     = rsl_pkg::ADDR_W;
    localparam int CFG_IDX_W  = rsl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = rsl_pkg::CFG_DATA_W;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 2 * (FRAC_BITS + 18);
    localparam int DRAIN_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_CMDS    = 46;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table: a command (repeated), or a register write.
    typedef struct packed {
        row_kind_t              kind;
        logic                   action;
        logic [15:0]            sx;
        logic [15:0]            sy;
        logic [15:0]            ex;
        logic [15:0]            ey;
        logic [7:0]             reps;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        rsl_pkg::pix_req_t      want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   cmd_valid;
    logic                   cmd_stall;
    rsl_pkg::cmd_req_t      cmd_req;
    logic                   pix_valid;
    logic                   pix_stall;
    rsl_pkg::pix_req_t      pix_req;

    run_slice_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_req   (cmd_req),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_req   (pix_req)
    );

    // Line walker state, mirroring the engine.
    logic [DIM_W-1:0]   fw_reg;
    logic [DIM_W-1:0]   fh_reg;
    logic [COLOR_W-1:0] color_reg;
    bit                 ln_busy;
    bit                 ln_swapped;
    bit                 maj_neg;
    bit                 min_neg;
    int                 maj_pos;
    int                 maj_end;
    int                 run_begin;
    int                 minor_pos;
    int                 run_len;
    longint             ratio;
    longint             overstep;

    rsl_pkg::pix_req_t  pending_pixels[$];
    dir_row_t           dir_tab[$];
    int                 err_cnt = 0;
    int                 cmd_cnt = 0;
    int                 pix_cnt = 0;
    int                 cfg_cnt = 0;
    bit                 cmd_idle_on = 1'b1;
    bit                 pix_idle_on = 1'b1;
    bit                 hold_req = 1'b0;

    always #1 clk = ~clk;

    // Frame sizes saturate in every use.
    function automatic int frame_w();
        return ({1'b0, fw_reg} > rsl_pkg::MAX_WIDTH) ? int'(rsl_pkg::MAX_WIDTH) : int'(fw_reg);
    endfunction

    function automatic int frame_h();
        return ({1'b0, fh_reg} > rsl_pkg::MAX_HEIGHT) ? int'(rsl_pkg::MAX_HEIGHT) :
                                                        int'(fh_reg);
    endfunction

    // Add one half, floor at zero, drop the fraction.
    function automatic int round_q(input longint v);
        longint r;
        r = v + (longint'(1) <<< (FRAC_BITS - 1));
        if (r < 0)
            r = 0;
        return int'(r >>> FRAC_BITS);
    endfunction

    function automatic int clamp_to(input int v, input int size);
        if (v >= size)
            v = size - 1;
        if (v < 0)
            v = 0;
        return v;
    endfunction

    function automatic void model_reset();
        fw_reg     = rsl_pkg::FRAME_WIDTH_RST;
        fh_reg     = rsl_pkg::FRAME_HEIGHT_RST;
        color_reg  = rsl_pkg::DRAW_COLOR_RST;
        ln_busy    = 1'b0;
        ln_swapped = 1'b0;
        maj_neg    = 1'b0;
        min_neg    = 1'b0;
        maj_pos    = 0;
        maj_end    = 0;
        run_begin  = 0;
        minor_pos  = 0;
        run_len    = 0;
        ratio      = 0;
        overstep   = 0;
    endfunction

    // Load: drop or clamp, pick the major axis and set up the first run.
    function automatic void line_load(input rsl_pkg::cmd_req_t c);
        int w, h, x1, y1, x2, y2, wdt, hgt, maj, mnr;
        bit xn, yn;
        w  = frame_w();
        h  = frame_h();
        x1 = int'(c.start_x);
        y1 = int'(c.start_y);
        x2 = int'(c.end_x);
        y2 = int'(c.end_y);
        ln_busy = 1'b0;
        if ((x1 >= w && x2 >= w) || (y1 >= h && y2 >= h) || (y1 < 0 && y2 < 0))
            return;
        x1 = clamp_to(x1, w);
        x2 = clamp_to(x2, w);
        y1 = clamp_to(y1, h);
        y2 = clamp_to(y2, h);
        xn  = x1 > x2;
        wdt = (xn ? x1 - x2 : x2 - x1) + 1;
        yn  = y1 > y2;
        hgt = (yn ? y1 - y2 : y2 - y1) + 1;
        ln_swapped = wdt < hgt;
        if (ln_swapped)
        begin
            maj = hgt;
            mnr = wdt;
            maj_pos = y1;
            maj_end = y2;
            minor_pos = x1;
            maj_neg = yn;
            min_neg = xn;
        end
        else
        begin
            maj = wdt;
            mnr = hgt;
            maj_pos = x1;
            maj_end = x2;
            minor_pos = y1;
            maj_neg = xn;
            min_neg = yn;
        end
        ratio     = ((longint'(maj) <<< (FRAC_BITS + 1)) + longint'(mnr))
                  / (longint'(2) * longint'(mnr));
        overstep  = 0;
        run_len   = round_q(ratio);
        run_begin = maj_pos;
        ln_busy   = 1'b1;
    endfunction

    // Tick: emit the current pixel and step along the run.
    function automatic bit line_step(output rsl_pkg::pix_req_t p);
        int row, col, nstart, nlen, scr;
        longint addr;
        bit is_last;
        p = '0;
        if (!ln_busy)
            return 1'b0;
        row = ln_swapped ? maj_pos : minor_pos;
        col = ln_swapped ? minor_pos : maj_pos;
        addr = longint'(row) * longint'(frame_w()) + longint'(col);
        p.pixel_address = addr[ADDR_W-1:0];
        p.pixel_value   = color_reg;
        is_last = 1'b0;
        if (maj_pos == maj_end)
        begin
            is_last = 1'b1;
        end
        else
        begin
            maj_pos += maj_neg ? -1 : 1;
            nstart = maj_neg ? run_begin - run_len : run_begin + run_len;
            if (maj_pos == nstart)
            begin
                overstep += (longint'(run_len) <<< FRAC_BITS) - ratio;
                nlen = round_q(ratio - overstep);
                scr  = ln_swapped ? frame_h() : frame_w();
                // Early stop looks at the upper side only.
                if (nstart + nlen > scr)
                begin
                    is_last = 1'b1;
                end
                else
                begin
                    run_begin = nstart;
                    run_len   = nlen;
                    minor_pos += min_neg ? -1 : 1;
                end
            end
        end
        if (is_last)
            ln_busy = 1'b0;
        p.last_pixel = is_last;
        return 1'b1;
    endfunction

    function automatic int cmd_gap();
        if (cmd_idle_on && $urandom_range(0, 3) == 0)
            return int'($urandom_range(1, 6));
        return 0;
    endfunction

    // Mostly in-frame coordinates, with edges and full-range values mixed in.
    function automatic logic [15:0] pick_coord(input int size);
        int lim;
        lim = (size > 0) ? size - 1 : 0;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'hFFFF;
            4: return 16'(size);
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    function automatic rsl_pkg::cmd_req_t tick_req();
        rsl_pkg::cmd_req_t c;
        c.action  = rsl_pkg::ACTION_TICK;
        c.start_x = 16'($urandom);
        c.start_y = 16'($urandom);
        c.end_x   = 16'($urandom);
        c.end_y   = 16'($urandom);
        return c;
    endfunction

    function automatic dir_row_t load_row(input int sx, input int sy, input int ex,
                                          input int ey);
        dir_row_t r;
        r = '0;
        r.kind   = ROW_CMD;
        r.action = rsl_pkg::ACTION_LOAD;
        r.sx     = 16'(sx);
        r.sy     = 16'(sy);
        r.ex     = 16'(ex);
        r.ey     = 16'(ey);
        r.reps   = 8'd1;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input int reps);
        dir_row_t r;
        r = '0;
        r.kind   = ROW_CMD;
        r.action = rsl_pkg::ACTION_TICK;
        r.reps   = 8'(reps);
        return r;
    endfunction

    // A tick whose pixel request is known by inspection.
    function automatic dir_row_t want_row(input int addr, input logic [COLOR_W-1:0] value,
                                          input bit is_last);
        dir_row_t r;
        r = tick_row(1);
        r.typed = 1'b1;
        r.want.pixel_address = ADDR_W'(addr);
        r.want.pixel_value   = value;
        r.want.last_pixel    = is_last;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Offer one command request, hold it until taken, then advance the model.
    task automatic push_cmd(input rsl_pkg::cmd_req_t c, input bit typed,
                            input rsl_pkg::pix_req_t want);
        int gap;
        bit made;
        rsl_pkg::pix_req_t got;
        gap = cmd_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_req   <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        made = 1'b0;
        if (c.action == rsl_pkg::ACTION_LOAD)
        begin
            line_load(c);
            cmd_cnt++;
        end
        else
        begin
            made = line_step(got);
            if (made)
                cmd_cnt++;
        end
        if (typed)
            pending_pixels.push_back(want);
        else if (made)
            pending_pixels.push_back(got);
        @(negedge clk);
    endtask

    // Register write; only issued while the engine is idle.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        unique case (idx)
            rsl_pkg::CFG_FRAME_WIDTH:  fw_reg = data[DIM_W-1:0];
            rsl_pkg::CFG_FRAME_HEIGHT: fh_reg = data[DIM_W-1:0];
            rsl_pkg::CFG_DRAW_COLOR:   color_reg = data;
            default: ;
        endcase
        cfg_cnt++;
    endtask

    // Wait for all predicted pixels, then let a load's divide finish.
    task automatic drain();
        int k;
        cmd_valid <= 1'b0;
        k = 0;
        while (pending_pixels.size() != 0 && k < DRAIN_LIMIT)
        begin
            @(negedge clk);
            k++;
        end
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: expected %0d more pixel requests, got none",
                     $time, pending_pixels.size());
            err_cnt++;
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A load with random endpoints, then ticks until the line ends or is cut.
    task automatic draw_sequence();
        rsl_pkg::cmd_req_t c;
        int cap, k;
        c.action  = rsl_pkg::ACTION_LOAD;
        c.start_x = pick_coord(frame_w());
        c.start_y = pick_coord(frame_h());
        c.end_x   = pick_coord(frame_w());
        c.end_y   = pick_coord(frame_h());
        push_cmd(c, 1'b0, '0);
        cap = $urandom_range(1, 48);
        k = 0;
        while (ln_busy && k < cap)
        begin
            push_cmd(tick_req(), 1'b0, '0);
            k++;
        end
        if ($urandom_range(0, 3) == 0)
            push_cmd(tick_req(), 1'b0, '0);
    endtask

    // Receiver stalls: random bursts, and one long hold-off on request.
    initial
    begin : pix_stall_drive
        int n;
        pix_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pix_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                pix_stall <= 1'b0;
            end
            else if (pix_idle_on && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 6);
                pix_stall <= 1'b1;
                repeat (n) @(negedge clk);
                pix_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted pixel request with the oldest prediction.
    always @(posedge clk)
    begin : pix_check
        rsl_pkg::pix_req_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            pix_cnt++;
            if (pending_pixels.size() == 0)
            begin
                err_cnt++;
                $display("%0t: expected no pixel request, got addr=%0d value=%h last=%0b",
                         $time, pix_req.pixel_address, pix_req.pixel_value,
                         pix_req.last_pixel);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_req.pixel_address !== want.pixel_address)
                begin
                    err_cnt++;
                    $display("%0t: pixel_address expected %0d got %0d",
                             $time, want.pixel_address, pix_req.pixel_address);
                end
                if (pix_req.pixel_value !== want.pixel_value)
                begin
                    err_cnt++;
                    $display("%0t: pixel_value expected %h got %h",
                             $time, want.pixel_value, pix_req.pixel_value);
                end
                if (pix_req.last_pixel !== want.last_pixel)
                begin
                    err_cnt++;
                    $display("%0t: last_pixel expected %0b got %0b",
                             $time, want.last_pixel, pix_req.last_pixel);
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("[run_slice_line_rasterizer] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int ph, k, sel, start_cnt;
        logic [DIM_W-1:0] w, h;
        rsl_pkg::cmd_req_t c;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= rsl_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        cmd_valid <= 1'b0;
        cmd_req   <= '0;
        model_reset();

        // Directed table: reset values, drop rules, clamping, replacement,
        // saturated and zero frame sizes, unmapped index, mid-line resize.
        dir_tab.push_back(tick_row(1));
        dir_tab.push_back(load_row(0, 0, 0, 0));
        dir_tab.push_back(want_row(0, rsl_pkg::DRAW_COLOR_RST, 1'b1));
        dir_tab.push_back(load_row(639, 479, 639, 479));
        dir_tab.push_back(want_row(307199, rsl_pkg::DRAW_COLOR_RST, 1'b1));
        dir_tab.push_back(load_row(640, 0, 700, 10));
        dir_tab.push_back(load_row(0, -1, 10, -5));
        dir_tab.push_back(load_row(3, 480, 5, 32767));
        dir_tab.push_back(tick_row(1));
        dir_tab.push_back(load_row(-32768, -32768, 32767, 32767));
        dir_tab.push_back(want_row(0, rsl_pkg::DRAW_COLOR_RST, 1'b0));
        dir_tab.push_back(load_row(2, 4, 1, 0));
        dir_tab.push_back(tick_row(6));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_FRAME_WIDTH, 32'h0000_0FFF));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_FRAME_HEIGHT, 32'hFFFF_F000));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_DRAW_COLOR, 32'hFFFF_FFFF));
        dir_tab.push_back(reg_row(CFG_UNMAPPED, 32'h1234_5678));
        dir_tab.push_back(load_row(-3, -3, 1, 5));
        dir_tab.push_back(want_row(0, 32'hFFFF_FFFF, 1'b0));
        dir_tab.push_back(want_row(1, 32'hFFFF_FFFF, 1'b1));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_FRAME_WIDTH, 32'd8));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_FRAME_HEIGHT, 32'd8));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_DRAW_COLOR, 32'h0000_0000));
        dir_tab.push_back(load_row(0, 0, 7, 1));
        dir_tab.push_back(reg_row(rsl_pkg::CFG_FRAME_WIDTH, 32'd2));
        dir_tab.push_back(tick_row(4));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain();
                reg_write(dir_tab[i].idx, dir_tab[i].data);
            end
            else
            begin
                for (k = 0; k < dir_tab[i].reps; k++)
                begin
                    c.action  = dir_tab[i].action;
                    c.start_x = dir_tab[i].sx;
                    c.start_y = dir_tab[i].sy;
                    c.end_x   = dir_tab[i].ex;
                    c.end_y   = dir_tab[i].ey;
                    push_cmd(c, dir_tab[i].typed, dir_tab[i].want);
                end
            end
        end

        // Random phases, each with its own frame size and color.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            if (ph == NUM_PHASES - 1)
            begin
                cmd_idle_on = 1'b0;
                pix_idle_on = 1'b0;
            end
            sel = $urandom_range(0, 11);
            w = DIM_W'($urandom_range(1, 40));
            h = DIM_W'($urandom_range(1, 40));
            if (ph == 1)
            begin
                w = DIM_W'($urandom_range(32, 64));
                h = DIM_W'($urandom_range(32, 64));
            end
            else if (ph == 2)
            begin
                w = 12'd2048;
                h = 12'hFFF;
            end
            else
            begin
                case (sel)
                    0: w = '0;
                    1: h = '0;
                    2: w = 12'd1;
                    3: w = 12'hFFF;
                    4: h = 12'd1;
                    default: ;
                endcase
            end
            reg_write(rsl_pkg::CFG_FRAME_WIDTH, {20'($urandom), w});
            reg_write(rsl_pkg::CFG_FRAME_HEIGHT, {20'($urandom), h});
            reg_write(rsl_pkg::CFG_DRAW_COLOR, $urandom);
            if ($urandom_range(0, 1) == 0)
                reg_write(CFG_UNMAPPED, $urandom);

            // Long output hold-off on a full-width line: the engine backs up.
            if (ph == 1)
            begin
                c = tick_req();
                c.action  = rsl_pkg::ACTION_LOAD;
                c.start_x = 16'h8000;
                c.start_y = 16'h0000;
                c.end_x   = 16'h7FFF;
                c.end_y   = 16'h0001;
                push_cmd(c, 1'b0, '0);
                hold_req = 1'b1;
                while (ln_busy)
                    push_cmd(tick_req(), 1'b0, '0);
            end

            start_cnt = cmd_cnt;
            while (cmd_cnt - start_cnt < PHASE_CMDS)
            begin
                if (ph != NUM_PHASES - 1)
                begin
                    cmd_idle_on = $urandom_range(0, 2) != 0;
                    pix_idle_on = $urandom_range(0, 2) != 0;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    c = tick_req();
                    c.action = 1'($urandom_range(0, 1));
                    push_cmd(c, 1'b0, '0);
                end
                else
                begin
                    draw_sequence();
                end
            end
        end

        drain();
        $display("Checked %0d pixel requests from %0d commands and %0d register writes.",
                 pix_cnt, cmd_cnt, cfg_cnt);
        $display("Covered dropped, clamped and replaced lines, odd frame sizes, back-pressure.");
        if (err_cnt == 0)
            $display("[run_slice_line_rasterizer] OK");
        else
            $display("[run_slice_line_rasterizer] ERROR");
        $finish;
    end

endmodule
